/* design/glyph_dot_plotter_sequencer_defines.svh */
// Assertion macros shared by the glyph plotter design files.
`ifndef GLYPH_DOT_PLOTTER_SEQUENCER_DEFINES_SVH
`define GLYPH_DOT_PLOTTER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GDPS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gdps same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GDPS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gdps next-cycle check failed");

`endif

/* design/gdps_pkg.sv */
package gdps_pkg;

  // Glyph geometry
  localparam int GLYPH_COLS = 5;
  localparam int GRID_ROWS  = 7;
  localparam int GLYPH_BITS = GLYPH_COLS * GRID_ROWS;
  localparam int NUM_GLYPHS = 26;

  localparam logic [2:0] LAST_ROW  = 3'(GRID_ROWS - 1);
  localparam logic [2:0] LAST_COL  = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] MID_ROW   = 3'd3;
  localparam logic [2:0] COL_SPACE = 3'd5;  // pen-up column for a non-letter
  localparam logic [2:0] COL_FINAL = 3'd6;  // pen-up column after a letter

  // Character codes
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Angle mapping
  localparam logic [6:0] BASE_LOW = 7'd60;
  localparam logic [5:0] X_LIMIT  = 6'd60;
  localparam logic [6:0] ARM_LOW  = 7'd80;

  // Grid point handed from the scanner to the angle mapper
  typedef struct packed {
    logic              valid;
    logic signed [8:0] x;
    logic [2:0]        row;
    logic              tap;
    logic              last;
  } point_t;

  // Column bytes per letter, bit r = row r
  localparam logic [4:0] GLYPH_ROM [NUM_GLYPHS][GLYPH_COLS] = '{
    '{5'h0E,5'h11,5'h1F,5'h11,5'h11}, '{5'h1E,5'h11,5'h1E,5'h11,5'h1E},
    '{5'h0E,5'h11,5'h10,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h11,5'h1E},
    '{5'h1F,5'h10,5'h1E,5'h10,5'h1F}, '{5'h1F,5'h10,5'h1E,5'h10,5'h10},
    '{5'h0E,5'h10,5'h17,5'h11,5'h0E}, '{5'h11,5'h11,5'h1F,5'h11,5'h11},
    '{5'h0E,5'h04,5'h04,5'h04,5'h0E}, '{5'h07,5'h02,5'h02,5'h12,5'h0C},
    '{5'h11,5'h12,5'h1C,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h1F},
    '{5'h11,5'h1B,5'h15,5'h11,5'h11}, '{5'h11,5'h19,5'h15,5'h13,5'h11},
    '{5'h0E,5'h11,5'h11,5'h11,5'h0E}, '{5'h1E,5'h11,5'h1E,5'h10,5'h10},
    '{5'h0E,5'h11,5'h11,5'h0E,5'h03}, '{5'h1E,5'h11,5'h1E,5'h12,5'h11},
    '{5'h0F,5'h10,5'h0E,5'h01,5'h1E}, '{5'h1F,5'h04,5'h04,5'h04,5'h04},
    '{5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h11,5'h11,5'h0A,5'h0A,5'h04},
    '{5'h11,5'h11,5'h15,5'h1B,5'h11}, '{5'h11,5'h0A,5'h04,5'h0A,5'h11},
    '{5'h11,5'h0A,5'h04,5'h04,5'h04}, '{5'h1F,5'h02,5'h04,5'h08,5'h1F}
  };

  // Whole glyph as a serial bit stream: column 0 row 0 first, rows 5..6 padded
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [4:0] idx);
    logic [GLYPH_BITS-1:0] v;
    v = '0;
    if (idx < 5'(NUM_GLYPHS)) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        v[c*GRID_ROWS +: GRID_ROWS] = {2'b00, GLYPH_ROM[idx][c]};
      end
    end
    return v;
  endfunction

  // 80 + (row * 40) / 6, truncated
  function automatic logic [6:0] arm_of_row(input logic [2:0] row);
    logic [6:0] a;
    case (row)
      3'd0:    a = 7'd80;
      3'd1:    a = 7'd86;
      3'd2:    a = 7'd93;
      3'd3:    a = 7'd100;
      3'd4:    a = 7'd106;
      3'd5:    a = 7'd113;
      default: a = 7'd120;
    endcase
    return a;
  endfunction

endpackage

/* design/gdps_scanner.sv */
`include "glyph_dot_plotter_sequencer_defines.svh"

module gdps_scanner (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [7:0]          char_code,
  input  logic signed [7:0]   left_col,
  output logic                busy,
  output gdps_pkg::point_t    pt
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } scan_state_t;

  scan_state_t state, state_next;

  logic [gdps_pkg::GLYPH_BITS-1:0] shreg;
  logic [2:0]                      col;
  logic [2:0]                      row;
  logic signed [7:0]               xo;

  logic [7:0] folded;
  logic [7:0] idx_full;
  logic       is_letter;
  logic       scan_done;

  // Case folding and letter test
  always_comb begin
    folded = char_code;
    if (char_code inside {[gdps_pkg::CHAR_LOWER_A:gdps_pkg::CHAR_LOWER_Z]}) begin
      folded = char_code - gdps_pkg::CASE_OFFSET;
    end
    is_letter = folded inside {[gdps_pkg::CHAR_UPPER_A:gdps_pkg::CHAR_UPPER_Z]};
    idx_full  = folded - gdps_pkg::CHAR_UPPER_A;
  end

  // Last bit of the glyph stream
  assign scan_done = (row == gdps_pkg::LAST_ROW) && (col == gdps_pkg::LAST_COL);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = is_letter ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Bit-serial glyph stream, row and column counters
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          xo    <= left_col;
          shreg <= gdps_pkg::glyph_bits(idx_full[4:0]);
          row   <= '0;
          col   <= is_letter ? 3'd0 : gdps_pkg::COL_SPACE;
        end
      end
      ST_SCAN: begin
        shreg <= shreg >> 1;
        if (row == gdps_pkg::LAST_ROW) begin
          row <= '0;
          col <= (col == gdps_pkg::LAST_COL) ? gdps_pkg::COL_FINAL : col + 3'd1;
        end else begin
          row <= row + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // Grid point for this cycle
  always_comb begin
    pt.valid = (state == ST_SCAN && shreg[0]) || (state == ST_FINISH);
    pt.x     = $signed({xo[7], xo}) + $signed({6'b000000, col});
    pt.row   = (state == ST_FINISH) ? gdps_pkg::MID_ROW : row;
    pt.tap   = (state == ST_SCAN);
    pt.last  = (state == ST_FINISH);
  end

  assign busy = (state != ST_IDLE);

  `GDPS_ASSERT_NXT(a_scan_ends, clk, rst, state == ST_SCAN && scan_done, state == ST_FINISH)
  `GDPS_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)

endmodule

/* design/gdps_angle_map.sv */
module gdps_angle_map (
  input  logic              clk,
  input  logic              rst,
  input  gdps_pkg::point_t  pt,
  output logic              strobe,
  output logic [6:0]        base_angle,
  output logic [6:0]        arm_angle,
  output logic              pen_tap,
  output logic              last
);

  logic [5:0] x_clamped;

  // Clamp x to the grid
  always_comb begin
    if (pt.x < 0) begin
      x_clamped = '0;
    end else if (pt.x > $signed({3'b000, gdps_pkg::X_LIMIT})) begin
      x_clamped = gdps_pkg::X_LIMIT;
    end else begin
      x_clamped = pt.x[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= pt.valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (pt.valid) begin
      base_angle <= gdps_pkg::BASE_LOW + {1'b0, x_clamped};
      arm_angle  <= gdps_pkg::arm_of_row(pt.row);
      pen_tap    <= pt.tap;
      last       <= pt.last;
    end
  end

endmodule

/* design/glyph_dot_plotter_sequencer.sv */
// Channel  | Handshake        | Beat
// ---------+------------------+-----------------------------------------------
// command  | start, busy      | char_code[7:0], left_col[7:0] (signed)
// result   | strobe (1 cycle) | base_angle[6:0], arm_angle[6:0], pen_tap, last
//
// A command is taken when start is high and busy is low.
// A letter holds busy while its 35 glyph bits are shifted one per cycle, then for the
// pen-up move; a non-letter holds busy for the pen-up move only. Each result is
// registered and appears in the cycle after its scan step.
// Synchronous active-high reset returns to idle with no result pending.
// The receiver cannot stall; each result beat stands for one cycle only.
`include "glyph_dot_plotter_sequencer_defines.svh"

module glyph_dot_plotter_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        char_code,
  input  logic signed [7:0] left_col,
  output logic              strobe,
  output logic [6:0]        base_angle,
  output logic [6:0]        arm_angle,
  output logic              pen_tap,
  output logic              last
);

  gdps_pkg::point_t pt;

  gdps_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .char_code (char_code),
    .left_col  (left_col),
    .busy      (busy),
    .pt        (pt)
  );

  gdps_angle_map u_angle_map (
    .clk        (clk),
    .rst        (rst),
    .pt         (pt),
    .strobe     (strobe),
    .base_angle (base_angle),
    .arm_angle  (arm_angle),
    .pen_tap    (pen_tap),
    .last       (last)
  );

  `GDPS_ASSERT_IMP(a_tap_xor_last, clk, rst, strobe, pen_tap != last)
  `GDPS_ASSERT_NXT(a_gap_after_last, clk, rst, strobe && last, !strobe)

endmodule
